// ===== hdl/lnws_pkg.sv =====
// Shared types and constants for the LCD nibble write sequencer.
package lnws_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_TWO_LINE   = 2'd0;
  localparam logic [1:0] REG_PULSE      = 2'd1;
  localparam logic [1:0] REG_BYTE_WAIT  = 2'd2;

  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_INIT  = 1'b1;

  localparam logic [15:0] HOLD_MAX        = 16'hFFFF;
  localparam logic [9:0]  PULSE_RESET     = 10'd5;
  localparam logic [15:0] BYTE_WAIT_RESET = 16'd2000;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] CMD_LINES_BIT    = 8'h08;
  localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_INC    = 8'h06;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;
  localparam logic [15:0] WAIT_LONG       = 16'd5000;
  localparam logic [15:0] WAIT_SHORT      = 16'd200;

  typedef struct packed {
    logic       opcode;
    logic       register_select;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic        rs_pin;
    logic        rw_pin;
    logic        enable_pin;
    logic [3:0]  bus_nibble;
    logic [15:0] hold_us;
    logic        last_state;
  } out_beat_t;

  // is_byte clear: single pulse of data[3:0] followed by wait_us
  typedef struct packed {
    logic        is_byte;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] wait_us;
    logic        last;
  } job_t;

endpackage

// ===== hdl/lnws_front.sv =====
// Front end: accepts items and expands them into nibble and byte jobs.
module lnws_front
  import lnws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  input  logic        two_line_mode,
  input  logic [15:0] byte_wait_us,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_data
);

  logic       busy;
  logic [2:0] step;
  logic       accept;

  function automatic job_t init_job(input logic [2:0] s, input logic lines,
                                    input logic [15:0] bw);
    job_t j;
    j.rs      = 1'b0;
    j.is_byte = s[2];
    j.last    = (s == 3'd7);
    j.wait_us = s[2] ? bw : ((s == 3'd0) ? WAIT_LONG : WAIT_SHORT);
    case (s)
      3'd0, 3'd1, 3'd2: j.data = {4'h0, NIB_WAKE};
      3'd3:             j.data = {4'h0, NIB_FOUR_BIT};
      3'd4:             j.data = CMD_FUNCTION_SET | (lines ? CMD_LINES_BIT : 8'h00);
      3'd5:             j.data = CMD_DISPLAY_OFF;
      3'd6:             j.data = CMD_CLEAR;
      default:          j.data = CMD_ENTRY_INC;
    endcase
    return j;
  endfunction

  assign in_ready = !busy && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    q_push = 1'b0;
    q_data = init_job(step, two_line_mode, byte_wait_us);
    if (busy) begin
      q_push = !q_full;
    end else if (accept) begin
      q_push = 1'b1;
      if (in_data.opcode == OP_INIT) begin
        q_data = init_job(3'd0, two_line_mode, byte_wait_us);
      end else begin
        q_data.is_byte = 1'b1;
        q_data.rs      = in_data.register_select;
        q_data.data    = in_data.data_byte;
        q_data.wait_us = byte_wait_us;
        q_data.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
    end else if (busy) begin
      if (!q_full) begin
        step <= step + 3'd1;
        if (step == 3'd7) busy <= 1'b0;
      end
    end else if (accept && in_data.opcode == OP_INIT) begin
      busy <= 1'b1;
      step <= 3'd1;
    end
  end

endmodule

// ===== hdl/lnws_queue.sv =====
// Small job queue between front and back end.
module lnws_queue
  import lnws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ===== hdl/lnws_back.sv =====
// Back end: steps each job through its pin states into the output register.
module lnws_back
  import lnws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [9:0] pulse_us,
  input  logic       q_empty,
  input  job_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data
);

  logic        cur_valid;
  job_t        cur;
  logic [1:0]  phase;
  logic        adv;
  logic        at_end;
  logic [16:0] sum;
  logic [15:0] hold;

  assign adv    = !out_valid || out_ready;
  assign at_end = (phase == 2'd3);
  assign q_pop  = !q_empty && (!cur_valid || (adv && at_end));
  assign sum    = {1'b0, cur.wait_us} + {7'b0, pulse_us};
  assign hold   = at_end ? (sum[16] ? HOLD_MAX : sum[15:0]) : {6'b0, pulse_us};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      phase     <= 2'd0;
    end else begin
      if (cur_valid && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        phase     <= q_data.is_byte ? 2'd0 : 2'd2;
      end else if (cur_valid && adv) begin
        phase <= phase + 2'd1;
        if (at_end) cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (cur_valid && adv) begin
      out_data.rs_pin     <= cur.rs;
      out_data.rw_pin     <= 1'b0;
      out_data.enable_pin <= !phase[0];
      out_data.bus_nibble <= phase[1] ? cur.data[3:0] : cur.data[7:4];
      out_data.hold_us    <= hold;
      out_data.last_state <= cur.last && at_end;
    end
  end

endmodule

// ===== hdl/lcd_nibble_write_sequencer.sv =====
// Top level of the LCD nibble write sequencer: config registers and datapath.
//
//  channel  | direction | handshake            | beat
//  in       | input     | in_valid / in_ready  | in_beat_t (opcode, rs, byte)
//  out      | output    | out_valid / out_ready| out_beat_t (pins, hold, last)
//  config   | input     | APB psel/penable     | 32-bit register write/read
//
// A byte write goes out as an enable pulse per nibble, high first; the back
// end emits one pin state per cycle while out_ready is high and a job waits.
// Reset restores two_line_mode 1, pulse_us 5, byte_wait_us 2000 and empties
// the job queue. The front end keeps accepting into the queue while the output
// stalls; in_ready drops while the queue is full or an init is expanding.
module lcd_nibble_write_sequencer
  import lnws_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        two_line_mode;
  logic [9:0]  pulse_us;
  logic [15:0] byte_wait_us;
  logic        wr_en;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  job_t        q_in;
  job_t        q_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_line_mode <= 1'b1;
      pulse_us      <= PULSE_RESET;
      byte_wait_us  <= BYTE_WAIT_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_TWO_LINE:  two_line_mode <= pwdata[0];
        REG_PULSE:     pulse_us      <= pwdata[9:0];
        REG_BYTE_WAIT: byte_wait_us  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TWO_LINE:  prdata = {31'b0, two_line_mode};
      REG_PULSE:     prdata = {22'b0, pulse_us};
      REG_BYTE_WAIT: prdata = {16'b0, byte_wait_us};
      default:       prdata = 32'b0;
    endcase
  end

  lnws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .two_line_mode (two_line_mode),
    .byte_wait_us  (byte_wait_us),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  lnws_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lnws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pulse_us  (pulse_us),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_last_on_fall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_state |-> !out_data.enable_pin)
    else $error("last pin state has enable high");

  a_high_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.enable_pin |-> out_data.hold_us == {6'b0, pulse_us})
    else $error("enable-high state hold differs from pulse time");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full && !q_pop |-> !(in_valid && in_ready))
    else $error("item accepted while job queue full");
`endif

endmodule
